// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bgp_pkg.sv =====
// Shared types, codes and pattern timings of the button gesture player.
`default_nettype none
package bgp_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;

  // Gesture codes
  localparam logic [2:0] G_SINGLE      = 3'd0;
  localparam logic [2:0] G_DOUBLE      = 3'd1;
  localparam logic [2:0] G_HOLD2       = 3'd2;
  localparam logic [2:0] G_HOLD6       = 3'd3;
  localparam logic [2:0] G_HOLD10      = 3'd4;
  localparam logic [2:0] GESTURE_COUNT = 3'd5;
  localparam logic [2:0] NO_GESTURE    = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ARG   = 2'd1;
  localparam logic [1:0] STATUS_BAD_STATE = 2'd2;

  // Classified operations passed from front to back
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_REQ     = 3'd1;
  localparam logic [2:0] OP_REQ_BAD = 3'd2;
  localparam logic [2:0] OP_START   = 3'd3;
  localparam logic [2:0] OP_NOP     = 3'd4;

  // Pattern timings in ms
  localparam int unsigned TIME_W = 14;
  localparam logic [TIME_W-1:0] SINGLE_REL_MS   = 14'd100;
  localparam logic [TIME_W-1:0] DOUBLE_GAP_MS   = 14'd200;
  localparam logic [TIME_W-1:0] DOUBLE_REL_MS   = 14'd300;
  localparam logic [TIME_W-1:0] HOLD2_REL_MS    = 14'd2100;
  localparam logic [TIME_W-1:0] HOLD6_REL_MS    = 14'd6100;
  localparam logic [TIME_W-1:0] HOLD10_REL_MS   = 14'd10100;
  localparam logic [TIME_W-1:0] TAIL_MS         = 14'd400;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        gesture;
    logic [TIME_W-1:0] rel_time;
    logic [TIME_W-1:0] fin_time;
    logic              phys;
    logic              sample_ok;
    logic              ridle;
    logic [15:0]       tick;
  } entry_t;

  // Last release time of a gesture's pattern
  function automatic logic [TIME_W-1:0] release_time(input logic [2:0] g);
    logic [TIME_W-1:0] r;
    case (g)
      G_SINGLE: r = SINGLE_REL_MS;
      G_DOUBLE: r = DOUBLE_REL_MS;
      G_HOLD2:  r = HOLD2_REL_MS;
      G_HOLD6:  r = HOLD6_REL_MS;
      default:  r = HOLD10_REL_MS;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bgp_front.sv =====
// Front stage: accepts items, classifies them and pushes them into the queue.
`default_nettype none
module bgp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic [1:0]            cmd,
  input  wire logic [2:0]            gesture,
  input  wire logic                  btn_pressed,
  input  wire logic                  btn_good,
  input  wire logic                  recog_idle,
  input  wire logic [15:0]           tick_ms,
  output logic                       push,
  output bgp_pkg::entry_t            push_data,
  input  wire logic                  q_full
);

  logic            f_valid;
  bgp_pkg::entry_t f_entry;
  bgp_pkg::entry_t dec;
  logic            accept;

  // Hold the input while the staged item cannot enter the queue
  assign req_stall = f_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push      = f_valid && !q_full;
  assign push_data = f_entry;

  // Classify the command and look up the pattern timings
  always_comb begin
    dec.gesture   = gesture;
    dec.rel_time  = bgp_pkg::release_time(gesture);
    dec.fin_time  = bgp_pkg::release_time(gesture) + bgp_pkg::TAIL_MS;
    dec.phys      = btn_pressed;
    dec.sample_ok = btn_good;
    dec.ridle     = recog_idle;
    dec.tick      = tick_ms;
    unique case (cmd)
      bgp_pkg::CMD_TICK:    dec.op = bgp_pkg::OP_TICK;
      bgp_pkg::CMD_REQUEST: dec.op = (gesture < bgp_pkg::GESTURE_COUNT) ?
                                     bgp_pkg::OP_REQ : bgp_pkg::OP_REQ_BAD;
      bgp_pkg::CMD_START:   dec.op = bgp_pkg::OP_START;
      default:              dec.op = bgp_pkg::OP_NOP;
    endcase
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bgp_queue.sv =====
// Short queue of classified items between front and back.
`default_nettype none
module bgp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bgp_back.sv =====
// Back stage: carries out each item against the player state and registers the result.
`default_nettype none
module bgp_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_not_empty,
  input  wire bgp_pkg::entry_t q_data,
  output logic             pop,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       status,
  output logic             sim_pressed,
  output logic             aborted,
  output logic             online,
  output logic [2:0]       active_gesture
);

  localparam logic [1:0] MODE_OFFLINE = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_BUSY    = 2'd2;
  localparam logic [1:0] MODE_GESTURE = 2'd3;
  localparam int unsigned TW = bgp_pkg::TIME_W;

  logic [1:0]    mode, mode_next;
  logic [2:0]    pending, pending_next;
  logic          started, started_next;
  logic [TW-1:0] elapsed, elapsed_next;
  logic [TW-1:0] rel_time, rel_time_next;
  logic [TW-1:0] fin_time, fin_time_next;

  logic [1:0]    st;
  logic          pressed;
  logic          abort;
  logic [TW-1:0] room;
  logic [TW-1:0] step;

  // Take an item when the result register is free or being emptied
  assign pop  = q_not_empty && (!res_valid || !res_stall);
  assign room = fin_time - elapsed;
  assign step = (q_data.tick < {2'b00, room}) ? q_data.tick[TW-1:0] : room;

  always_comb begin
    mode_next     = mode;
    pending_next  = pending;
    started_next  = started;
    elapsed_next  = elapsed;
    rel_time_next = rel_time;
    fin_time_next = fin_time;
    pressed       = 1'b0;
    abort         = 1'b0;
    st            = bgp_pkg::STATUS_OK;
    unique case (q_data.op)
      bgp_pkg::OP_REQ: begin
        if (mode == MODE_IDLE) begin
          mode_next     = MODE_GESTURE;
          pending_next  = q_data.gesture;
          rel_time_next = q_data.rel_time;
          fin_time_next = q_data.fin_time;
        end else begin
          st = bgp_pkg::STATUS_BAD_STATE;
        end
      end
      bgp_pkg::OP_REQ_BAD: begin
        st = bgp_pkg::STATUS_BAD_ARG;
      end
      bgp_pkg::OP_START: begin
        mode_next = MODE_IDLE;
      end
      bgp_pkg::OP_TICK: begin
        if (mode != MODE_GESTURE) begin
          // Follow the physical button outside a gesture
          if (mode != MODE_OFFLINE) begin
            mode_next = (q_data.sample_ok && !q_data.phys && q_data.ridle) ?
                        MODE_IDLE : MODE_BUSY;
          end
        end else if (!started && !q_data.ridle) begin
          // Drop the gesture: recognizer busy before playback
          mode_next = MODE_BUSY;
        end else if (!q_data.sample_ok || q_data.phys) begin
          // Abort on a real press or an invalid sample
          started_next = 1'b0;
          elapsed_next = '0;
          mode_next    = MODE_BUSY;
          abort        = 1'b1;
        end else begin
          started_next = 1'b1;
          if (pending == bgp_pkg::G_DOUBLE) begin
            pressed = (elapsed < bgp_pkg::SINGLE_REL_MS) ||
                      ((elapsed >= bgp_pkg::DOUBLE_GAP_MS) &&
                       (elapsed < bgp_pkg::DOUBLE_REL_MS));
          end else begin
            pressed = (elapsed < rel_time);
          end
          if (elapsed >= fin_time) begin
            if (q_data.ridle) begin
              started_next = 1'b0;
              elapsed_next = '0;
              mode_next    = MODE_IDLE;
            end
          end else begin
            elapsed_next = elapsed + step;
          end
        end
        st = (mode_next == MODE_OFFLINE) ? bgp_pkg::STATUS_BAD_STATE : bgp_pkg::STATUS_OK;
      end
      default: begin
        st = (mode == MODE_OFFLINE) ? bgp_pkg::STATUS_BAD_STATE : bgp_pkg::STATUS_OK;
      end
    endcase
  end

  // Update player state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_OFFLINE;
      pending <= '0;
      started <= 1'b0;
      elapsed <= '0;
    end else if (pop) begin
      mode    <= mode_next;
      pending <= pending_next;
      started <= started_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rel_time <= rel_time_next;
      fin_time <= fin_time_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status         <= st;
      sim_pressed    <= pressed;
      aborted        <= abort;
      online         <= (mode_next != MODE_OFFLINE);
      active_gesture <= (mode_next == MODE_GESTURE) ? pending_next : bgp_pkg::NO_GESTURE;
    end
  end

endmodule
`default_nettype wire

// ===== sv/button_gesture_player.sv =====
// Top level of the button gesture player.
`default_nettype none
// Plays a synthetic click, double click or 2/6/10 s hold as a button level, one
// item per command. Throughput is one item per clock while res_stall is low: the
// back stage updates the mode, pending gesture and elapsed time once per item. A
// result reaches res_valid through the front register, then the queue, then the
// result register. The queue of QUEUE_DEPTH items lets the input keep flowing
// for a while when the result side stalls; once it and the front register are
// full, req_stall rises.
module button_gesture_player #(
  parameter int unsigned QUEUE_DEPTH = bgp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  gesture,
  input  wire logic        btn_pressed,
  input  wire logic        btn_good,
  input  wire logic        recog_idle,
  input  wire logic [15:0] tick_ms,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       status,
  output logic             sim_pressed,
  output logic             aborted,
  output logic             online,
  output logic [2:0]       active_gesture
);

  localparam int unsigned ENTRY_W = $bits(bgp_pkg::entry_t);

  logic            push;
  bgp_pkg::entry_t push_data;
  logic            q_full;
  logic            pop;
  logic            q_not_empty;
  bgp_pkg::entry_t q_data;

  bgp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .gesture     (gesture),
    .btn_pressed (btn_pressed),
    .btn_good    (btn_good),
    .recog_idle  (recog_idle),
    .tick_ms     (tick_ms),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  bgp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rdata     (q_data)
  );

  bgp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_data         (q_data),
    .pop            (pop),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .sim_pressed    (sim_pressed),
    .aborted        (aborted),
    .online         (online),
    .active_gesture (active_gesture)
  );

endmodule
`default_nettype wire

// ===== sv/bgp_checker.sv =====
// Port-level checker of the button gesture player and its bind.
`default_nettype none
`include "assert_macros.svh"
module bgp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [1:0] status,
  input wire logic       sim_pressed,
  input wire logic       aborted,
  input wire logic       online,
  input wire logic [2:0] active_gesture
);

  // A stalled result stays offered
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)

  // Offline never shows a gesture in play
  `ASSERT_IMPLY(a_offline_none, clk, rst, res_valid && !online,
                active_gesture == bgp_pkg::NO_GESTURE)

  // A pressed level only comes from a gesture still in play
  `ASSERT_IMPLY(a_press_in_play, clk, rst, res_valid && sim_pressed,
                online && active_gesture != bgp_pkg::NO_GESTURE)

  // An abort releases the level and leaves the block busy and online
  `ASSERT_IMPLY(a_abort_clean, clk, rst, res_valid && aborted,
                !sim_pressed && online && status == bgp_pkg::STATUS_OK &&
                active_gesture == bgp_pkg::NO_GESTURE)

endmodule

bind button_gesture_player bgp_checker u_bgp_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .status         (status),
  .sim_pressed    (sim_pressed),
  .aborted        (aborted),
  .online         (online),
  .active_gesture (active_gesture)
);
`default_nettype wire
